>>> sv/lbsa_pkg.sv
// ----------------------------------------------------------------------------
// lbsa_pkg
// Shared widths, constants and the angle step table for the blur/Sobel block.
// ----------------------------------------------------------------------------
package lbsa_pkg;

  localparam int MaxLineDef = 1024;
  localparam int LumaW      = 17;
  localparam int BlurW      = 21;
  localparam int SumW       = 23;
  localparam int CfgW       = 11;
  localparam logic [CfgW-1:0] LineLenReset = 11'd640;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CALC,
    ST_ANGLE,
    ST_OUT
  } state_t;

  // Q30 tangent-comparison pairs: cosine then sine for degree d (0..44; a larger d gives 44)
  function automatic logic [61:0] trig_q30(input logic [5:0] d);
    logic [63:0] c;
    logic [63:0] s;
    logic [63:0] nc;
    logic [63:0] ns;
    c = 64'd1 << 30;
    s = 64'd0;
    for (int k = 1; k <= 44; k++) begin
      if (k <= int'(d)) begin
        nc = (c * 64'd1073578288 - s * 64'd18739379 + (64'd1 << 29)) >> 30;
        ns = (s * 64'd1073578288 + c * 64'd18739379 + (64'd1 << 29)) >> 30;
        c  = nc;
        s  = ns;
      end
    end
    return {c[30:0], s[30:0]};
  endfunction

endpackage

>>> sv/luma_blur_sobel_angle.sv
// ----------------------------------------------------------------------------
// luma_blur_sobel_angle
// RGB raster to luma, 3x3 1-2-1 blur, 3x3 Sobel sums and gradient angle.
// ----------------------------------------------------------------------------
// channel | ports                                   | handshake
// in      | in_red/green/blue, in_frame_start       | in_valid, in_stall
// out     | out_vertical_sum .. out_valid_res       | out_valid, out_stall
// cfg     | cfg_we, cfg_wdata                       | write on cfg_we
//
// One word at a time: accept, read the two line memories, form the blur
// and Sobel sums, then an angle search (one degree a cycle, one 31x23
// multiply pair), then hold the result until taken. The angle search is
// skipped when the result is invalid, the vertical sum is zero or |H|
// equals |V|.
// Reset: synchronous rst_n clears counters, windows and FSM; line memories
// are left unset, which is safe as invalid results are forced to zero.
// A stalled result holds; no new word is taken until it leaves.
module luma_blur_sobel_angle #(
  parameter int MAX_LINE = lbsa_pkg::MaxLineDef
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [7:0]                   in_red,
  input  logic [7:0]                   in_green,
  input  logic [7:0]                   in_blue,
  input  logic                         in_frame_start,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [lbsa_pkg::SumW-1:0] out_vertical_sum,
  output logic signed [lbsa_pkg::SumW-1:0] out_horizontal_sum,
  output logic signed [7:0]            out_angle_degrees,
  output logic                         out_valid_res,
  input  logic                         cfg_we,
  input  logic [lbsa_pkg::CfgW-1:0]    cfg_wdata
);
  import lbsa_pkg::*;

  localparam int AW = $clog2(MAX_LINE);
  // wide enough for both the register value and MAX_LINE itself
  localparam int EW = (AW + 2 > CfgW + 1) ? AW + 2 : CfgW + 1;

  state_t state_r, state_nxt;

  logic [CfgW-1:0] line_len_r;
  logic [AW:0]     col_r;
  logic [2:0]      row_r;

  // two-row memories: each entry holds {older row, newer row}
  logic [2*LumaW-1:0] luma_mem [MAX_LINE];
  logic [2*BlurW-1:0] blur_mem [MAX_LINE];
  logic [2*LumaW-1:0] luma_rd_r;
  logic [2*BlurW-1:0] blur_rd_r;

  logic [LumaW-1:0] lw_r [9];
  logic [BlurW-1:0] bw_r [9];

  logic [AW-1:0]    addr_r;
  logic [LumaW-1:0] luma_r;
  logic             valid_pix_r;

  logic signed [SumW-1:0] vt_r, hz_r;
  logic [SumW-1:0]  num_r, den_r;
  logic [5:0]       deg_r;
  logic [6:0]       cnt_r;
  logic             swap_r, neg_r, done_r;
  logic signed [7:0] ang_r;

  // column bookkeeping
  logic [AW:0]   col_cur;
  logic [2:0]    row_cur;
  logic [EW-1:0] eff_len;
  always_comb begin
    col_cur = in_frame_start ? '0 : col_r;
    row_cur = in_frame_start ? '0 : row_r;
    if (col_cur >= (AW+1)'(MAX_LINE)) col_cur = '0;
    eff_len = EW'(line_len_r);
    if (eff_len < EW'(5)) eff_len = EW'(5);
    if (eff_len > EW'(MAX_LINE)) eff_len = EW'(MAX_LINE);
  end

  logic accept;
  assign accept = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (accept) state_nxt = ST_READ;
      ST_READ:  state_nxt = ST_CALC;
      ST_CALC:  state_nxt = ST_ANGLE;
      ST_ANGLE: if (done_r) state_nxt = ST_OUT;
      ST_OUT:   if (!out_stall) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    out_valid          = (state_r == ST_OUT);
    out_valid_res      = valid_pix_r;
    out_vertical_sum   = valid_pix_r ? vt_r : '0;
    out_horizontal_sum = valid_pix_r ? hz_r : '0;
    out_angle_degrees  = valid_pix_r ? ang_r : '0;
  end

  // luma of the incoming word
  logic [LumaW-1:0] luma_in;
  assign luma_in = LumaW'(in_red) * LumaW'(77) + LumaW'(in_green) * LumaW'(150)
                 + LumaW'(in_blue) * LumaW'(29);

  // memory ports: read on accept, luma written back in read, blur in calc
  logic [BlurW-1:0] blur_val;
  always_ff @(posedge clk) begin
    if (accept) begin
      luma_rd_r <= luma_mem[col_cur[AW-1:0]];
      blur_rd_r <= blur_mem[col_cur[AW-1:0]];
    end
    if (state_r == ST_READ) luma_mem[addr_r] <= {luma_rd_r[LumaW-1:0], luma_r};
    if (state_r == ST_CALC) blur_mem[addr_r] <= {blur_rd_r[BlurW-1:0], blur_val};
  end

  // blur over the luma window after this word's shift
  logic [LumaW-1:0] nl [9];
  always_comb begin
    nl[0] = lw_r[1]; nl[1] = lw_r[2]; nl[2] = luma_rd_r[2*LumaW-1:LumaW];
    nl[3] = lw_r[4]; nl[4] = lw_r[5]; nl[5] = luma_rd_r[LumaW-1:0];
    nl[6] = lw_r[7]; nl[7] = lw_r[8]; nl[8] = luma_r;
  end

  logic [BlurW-1:0] blur_nxt;
  assign blur_nxt = BlurW'(nl[0]) + (BlurW'(nl[1]) << 1) + BlurW'(nl[2])
                  + (BlurW'(nl[3]) << 1) + (BlurW'(nl[4]) << 2) + (BlurW'(nl[5]) << 1)
                  + BlurW'(nl[6]) + (BlurW'(nl[7]) << 1) + BlurW'(nl[8]);
  logic [BlurW-1:0] blur_r;
  assign blur_val = blur_r;

  logic [BlurW-1:0] nb [9];
  always_comb begin
    nb[0] = bw_r[1]; nb[1] = bw_r[2]; nb[2] = blur_rd_r[2*BlurW-1:BlurW];
    nb[3] = bw_r[4]; nb[4] = bw_r[5]; nb[5] = blur_rd_r[BlurW-1:0];
    nb[6] = bw_r[7]; nb[7] = bw_r[8]; nb[8] = blur_r;
  end

  logic signed [SumW:0] vt_c, hz_c;
  assign vt_c = $signed({2'b0, nb[0]}) + $signed({1'b0, nb[1], 1'b0}) + $signed({2'b0, nb[2]})
              - $signed({2'b0, nb[6]}) - $signed({1'b0, nb[7], 1'b0}) - $signed({2'b0, nb[8]});
  assign hz_c = $signed({2'b0, nb[2]}) + $signed({1'b0, nb[5], 1'b0}) + $signed({2'b0, nb[8]})
              - $signed({2'b0, nb[0]}) - $signed({1'b0, nb[3], 1'b0}) - $signed({2'b0, nb[6]});

  logic [SumW-1:0] av, ah;
  assign av = vt_c[SumW] ? SumW'(-vt_c) : vt_c[SumW-1:0];
  assign ah = hz_c[SumW] ? SumW'(-hz_c) : hz_c[SumW-1:0];

  // cos/sin table, fixed at elaboration
  logic [61:0] trig_tab [64];
  for (genvar g = 0; g < 64; g++) begin : g_trig
    localparam logic [61:0] TrigVal = trig_q30(6'(g));
    assign trig_tab[g] = TrigVal;
  end

  // one degree per cycle: num*cos_d >= den*sin_d
  logic [61:0] cs;
  logic [53:0] pc, ps;
  assign cs = trig_tab[deg_r];
  assign pc = num_r * cs[61:31];
  assign ps = den_r * cs[30:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      line_len_r <= LineLenReset;
      col_r      <= '0;
      row_r      <= '0;
      for (int i = 0; i < 9; i++) begin
        lw_r[i] <= '0;
        bw_r[i] <= '0;
      end
      done_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) line_len_r <= cfg_wdata;
      if (accept) begin
        addr_r      <= col_cur[AW-1:0];
        luma_r      <= luma_in;
        valid_pix_r <= (row_cur >= 3'd4) && (col_cur >= (AW+1)'(4));
        if (EW'(col_cur) + EW'(1) >= eff_len) begin
          col_r <= '0;
          if (row_cur < 3'd4) row_r <= row_cur + 3'd1;
          else row_r <= row_cur;
        end else begin
          col_r <= col_cur + (AW+1)'(1);
          row_r <= row_cur;
        end
      end
      if (state_r == ST_READ) begin
        lw_r   <= nl;
        blur_r <= blur_nxt;
      end
      if (state_r == ST_CALC) begin
        bw_r   <= nb;
        vt_r   <= vt_c[SumW-1:0];
        hz_r   <= hz_c[SumW-1:0];
        swap_r <= ah > av;
        num_r  <= (ah > av) ? av : ah;
        den_r  <= (ah > av) ? ah : av;
        neg_r  <= (vt_c[SumW] != hz_c[SumW]) && (hz_c != '0);
        deg_r  <= 6'd1;
        cnt_r  <= '0;
        // invalid words skip the search; their fields are forced to zero
        done_r <= !valid_pix_r || (vt_c == '0) || (ah == av);
        if (vt_c == '0) ang_r <= 8'sd90;
        else if (ah == av) ang_r <= ((vt_c[SumW] != hz_c[SumW]) && (hz_c != '0)) ? -8'sd45 : 8'sd45;
      end
      if (state_r == ST_ANGLE && !done_r) begin
        if (pc >= ps && deg_r <= 6'd44) begin
          cnt_r <= cnt_r + 7'd1;
          deg_r <= deg_r + 6'd1;
        end else begin
          done_r <= 1'b1;
          ang_r  <= neg_r ? -8'(swap_r ? 7'd89 - cnt_r : cnt_r)
                          : 8'(swap_r ? 7'd89 - cnt_r : cnt_r);
        end
      end
      if (state_r == ST_OUT) done_r <= 1'b0;
    end
  end

  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> in_stall) else $error("word taken while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_angle_degrees)))
    else $error("result dropped under stall");
  a_ang_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_angle_degrees <= 8'sd90 && out_angle_degrees >= -8'sd90))
    else $error("angle out of range");
endmodule
